// ----- hdl/disk_request_to_chs_commands_assert.svh -----
// assertion macros shared by the disk request converter
`ifndef DISK_REQUEST_TO_CHS_COMMANDS_ASSERT_SVH
`define DISK_REQUEST_TO_CHS_COMMANDS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DRTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DRTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/drtc_pkg.sv -----
// shared types and constants of the disk request converter
package drtc_pkg;

  localparam int BLOCK_W   = 22;  // 21-bit start plus room for a run past the top
  localparam int SPT_W     = 7;
  localparam int HDS_W     = 6;
  localparam int CTL_W     = 8;
  localparam int CNT_W     = 7;
  localparam int DIVISOR_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam int COUNT_LIMIT = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPT0  = 3'd0,
    REG_HDS0  = 3'd1,
    REG_CTL0  = 3'd2,
    REG_SPT1  = 3'd3,
    REG_HDS1  = 3'd4,
    REG_CTL1  = 3'd5,
    REG_LIMIT = 3'd6
  } cfg_reg_e;

  localparam logic [SPT_W-1:0] SPT_RESET   = 7'd17;
  localparam logic [HDS_W-1:0] HDS_RESET   = 6'd4;
  localparam logic [CTL_W-1:0] CTL_RESET   = 8'd0;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd1;

  // geometry of the selected drive, zero spt, hds and limit values already forced to one
  typedef struct packed {
    logic [SPT_W-1:0] spt;
    logic [HDS_W-1:0] hds;
    logic [CTL_W-1:0] ctl;
    logic [CNT_W-1:0] limit;
  } geom_t;

  typedef struct packed {
    logic                 start;
    logic [BLOCK_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [BLOCK_W-1:0]   quot;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- hdl/disk_request_to_chs_commands.sv -----
// disk request to cylinder/head/sector command blocks, top level
//
//  channel  ports                                   direction
//  in       in_valid/in_stall, request fields       request words in
//  out      out_valid/out_stall, command fields     one command word per chunk
//  cfg      cfg_we, cfg_index, cfg_wdata            geometry and limit writes
//
// each chunk runs two passes of the shared 22-step divider: block by sectors
// per track, then track by heads; a chunk is divided once the request is taken
// or once the previous word of the request leaves
// in_stall is high from acceptance until the last word of the request leaves;
// a request with zero sectors is taken and yields nothing
// out_stall holds the word in its register; rst_n is synchronous
module disk_request_to_chs_commands #(
  parameter logic [7:0] READ_OPCODE  = 8'd8,
  parameter logic [7:0] WRITE_OPCODE = 8'd10,
  parameter int         SECTOR_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic                           in_drive,
  input  logic [20:0]                    in_start_block,
  input  logic [drtc_pkg::CNT_W-1:0]     in_sector_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_opcode_byte,
  output logic [7:0]                     out_drive_head_byte,
  output logic [7:0]                     out_cyl_high_sector_byte,
  output logic [7:0]                     out_cyl_low_byte,
  output logic [7:0]                     out_chunk_count_byte,
  output logic [7:0]                     out_control_out_byte,
  output logic [15:0]                    out_transfer_bytes,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [drtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drtc_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import drtc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic               start_r, start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               action_r, action_nxt;
  logic               drive_r, drive_nxt;
  logic [BLOCK_W-1:0] block_r, block_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [BLOCK_W-1:0] track_r, track_nxt;
  logic [5:0]         sector_r, sector_nxt;
  logic               in_accept;
  logic [CNT_W-1:0]   count_in;
  logic [CNT_W-1:0]   chunk;
  logic [CNT_W-1:0]   count_left;
  logic [31:0]        xfer_full;

  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  dh_r, dh_nxt;
  logic [7:0]  chs_r, chs_nxt;
  logic [7:0]  cyl_lo_r, cyl_lo_nxt;
  logic [7:0]  chunk_r, chunk_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [15:0] xfer_r, xfer_nxt;
  logic        last_r, last_nxt;

  geom_t    geom;
  div_req_t dreq;
  div_rsp_t drsp;

  drtc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .drive_sel (drive_r),
    .geom      (geom)
  );

  drtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // first pass divides the block, second pass the track
  always_comb begin
    dreq.start    = start_r;
    dreq.dividend = (state_r == ST_DIV2) ? track_r : block_r;
    dreq.divisor  = (state_r == ST_DIV2) ? {1'b0, geom.hds} : geom.spt;
  end

  assign in_accept  = in_valid && !in_stall;
  assign count_in   = (in_sector_count > CNT_W'(COUNT_LIMIT)) ?
                      CNT_W'(COUNT_LIMIT) : in_sector_count;
  assign chunk      = (count_r < geom.limit) ? count_r : geom.limit;
  assign count_left = count_r - chunk;
  assign xfer_full  = 32'(chunk) * 32'(SECTOR_BYTES);

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    action_nxt    = action_r;
    drive_nxt     = drive_r;
    block_nxt     = block_r;
    count_nxt     = count_r;
    track_nxt     = track_r;
    sector_nxt    = sector_r;
    opcode_nxt    = opcode_r;
    dh_nxt        = dh_r;
    chs_nxt       = chs_r;
    cyl_lo_nxt    = cyl_lo_r;
    chunk_nxt     = chunk_r;
    ctl_nxt       = ctl_r;
    xfer_nxt      = xfer_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          action_nxt = in_action;
          drive_nxt  = in_drive;
          block_nxt  = {1'b0, in_start_block};
          count_nxt  = count_in;
          if (count_in != '0) begin
            state_nxt = ST_DIV1;
            start_nxt = 1'b1;
          end
        end
      end
      ST_DIV1: begin
        if (drsp.done) begin
          track_nxt  = drsp.quot;
          sector_nxt = drsp.rem[5:0];
          state_nxt  = ST_DIV2;
          start_nxt  = 1'b1;
        end
      end
      ST_DIV2: begin
        if (drsp.done) begin
          opcode_nxt    = action_r ? WRITE_OPCODE : READ_OPCODE;
          dh_nxt        = {2'b00, drive_r, drsp.rem[4:0]};
          chs_nxt       = {drsp.quot[9:8], sector_r};
          cyl_lo_nxt    = drsp.quot[7:0];
          chunk_nxt     = {1'b0, chunk};
          ctl_nxt       = geom.ctl;
          xfer_nxt      = xfer_full[15:0];
          last_nxt      = (count_left == '0);
          count_nxt     = count_left;
          block_nxt     = block_r + BLOCK_W'(chunk);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (count_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DIV1;
            start_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    drive_r  <= drive_nxt;
    block_r  <= block_nxt;
    count_r  <= count_nxt;
    track_r  <= track_nxt;
    sector_r <= sector_nxt;
    opcode_r <= opcode_nxt;
    dh_r     <= dh_nxt;
    chs_r    <= chs_nxt;
    cyl_lo_r <= cyl_lo_nxt;
    chunk_r  <= chunk_nxt;
    ctl_r    <= ctl_nxt;
    xfer_r   <= xfer_nxt;
    last_r   <= last_nxt;
  end

  assign in_stall                 = (state_r != ST_IDLE);
  assign out_valid                = out_valid_r;
  assign out_opcode_byte          = opcode_r;
  assign out_drive_head_byte      = dh_r;
  assign out_cyl_high_sector_byte = chs_r;
  assign out_cyl_low_byte         = cyl_lo_r;
  assign out_chunk_count_byte     = chunk_r;
  assign out_control_out_byte     = ctl_r;
  assign out_transfer_bytes       = xfer_r;
  assign out_last                 = last_r;

  `include "disk_request_to_chs_commands_assert.svh"

  `DRTC_ASSERT_NOW(a_busy_while_word, out_valid, in_stall, "word pending while input open")
  `DRTC_ASSERT_NEXT(a_idle_after_last, out_valid && !out_stall && out_last, !in_stall && !out_valid, "not idle after last word")
  `DRTC_ASSERT_NEXT(a_zero_count_idle, in_accept && in_sector_count == '0, !in_stall && !out_valid, "zero count request started work")
  `DRTC_ASSERT_NOW(a_div_done_in_div, drsp.done, state_r == ST_DIV1 || state_r == ST_DIV2, "divider done outside a divide pass")

endmodule

// ----- hdl/drtc_cfg.sv -----
// configuration registers and per-drive geometry select
module drtc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [drtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drtc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           drive_sel,
  output drtc_pkg::geom_t                geom
);
  import drtc_pkg::*;

  logic [SPT_W-1:0] spt0_r, spt1_r;
  logic [HDS_W-1:0] hds0_r, hds1_r;
  logic [CTL_W-1:0] ctl0_r, ctl1_r;
  logic [CNT_W-1:0] limit_r;
  logic [SPT_W-1:0] spt_sel;
  logic [HDS_W-1:0] hds_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt0_r  <= SPT_RESET;
      hds0_r  <= HDS_RESET;
      ctl0_r  <= CTL_RESET;
      spt1_r  <= SPT_RESET;
      hds1_r  <= HDS_RESET;
      ctl1_r  <= CTL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPT0:  spt0_r  <= cfg_wdata[SPT_W-1:0];
        REG_HDS0:  hds0_r  <= cfg_wdata[HDS_W-1:0];
        REG_CTL0:  ctl0_r  <= cfg_wdata[CTL_W-1:0];
        REG_SPT1:  spt1_r  <= cfg_wdata[SPT_W-1:0];
        REG_HDS1:  hds1_r  <= cfg_wdata[HDS_W-1:0];
        REG_CTL1:  ctl1_r  <= cfg_wdata[CTL_W-1:0];
        REG_LIMIT: limit_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spt_sel    = drive_sel ? spt1_r : spt0_r;
    hds_sel    = drive_sel ? hds1_r : hds0_r;
    // a zero spt, hds or limit value behaves as one
    geom.spt   = (spt_sel == '0) ? SPT_W'(1) : spt_sel;
    geom.hds   = (hds_sel == '0) ? HDS_W'(1) : hds_sel;
    geom.ctl   = drive_sel ? ctl1_r : ctl0_r;
    geom.limit = (limit_r == '0) ? CNT_W'(1) : limit_r;
  end

endmodule

// ----- hdl/drtc_div.sv -----
// shared radix-2 restoring divider, one quotient bit per cycle
module drtc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  drtc_pkg::div_req_t req,
  output drtc_pkg::div_rsp_t rsp
);
  import drtc_pkg::*;

  localparam int STEPS = BLOCK_W;
  localparam int CNT_BITS = $clog2(STEPS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [BLOCK_W-1:0]   q_r, q_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial    = {rem_r, q_r[BLOCK_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(STEPS);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back into its width
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      q_nxt   = {q_r[BLOCK_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- tb/disk_request_to_chs_commands_test.sv -----
// testbench for the disk request to cylinder/head/sector command converter
`timescale 1ns / 1ps

module disk_request_to_chs_commands_test;
  import drtc_pkg::*;

  localparam logic [7:0] OPC_READ         = 8'd8;
  localparam logic [7:0] OPC_WRITE        = 8'd10;
  localparam int         BYTES_PER_SECTOR = 512;
  localparam logic       ACT_READ         = 1'b0;
  localparam logic       ACT_WRITE        = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [20:0] TOP_BLOCK       = 21'h1FFFFF;
  localparam int IDLE_GAP    = 120;
  localparam int CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic             action;
    logic             drive;
    logic [20:0]      start_block;
    logic [CNT_W-1:0] sector_count;
  } chs_request_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  drive_head;
    logic [7:0]  cyl_high_sector;
    logic [7:0]  cyl_low;
    logic [7:0]  chunk_count;
    logic [7:0]  control;
    logic [15:0] transfer;
    logic        last;
  } chs_word_t;

  typedef logic [6:0][CFG_DAT_W-1:0] geometry_set_t;

  class chs_scoreboard;
    logic [SPT_W-1:0] spt_cfg [2];
    logic [HDS_W-1:0] hds_cfg [2];
    logic [CTL_W-1:0] ctl_cfg [2];
    logic [CNT_W-1:0] chunk_limit;
    chs_word_t words_due [$];
    int errors;
    int requests;
    int words_seen;

    function new();
      spt_cfg[0] = SPT_RESET;
      spt_cfg[1] = SPT_RESET;
      hds_cfg[0] = HDS_RESET;
      hds_cfg[1] = HDS_RESET;
      ctl_cfg[0] = CTL_RESET;
      ctl_cfg[1] = CTL_RESET;
      chunk_limit = LIMIT_RESET;
      errors = 0;
      requests = 0;
      words_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_SPT0:  spt_cfg[0] = val[SPT_W-1:0];
        REG_HDS0:  hds_cfg[0] = val[HDS_W-1:0];
        REG_CTL0:  ctl_cfg[0] = val[CTL_W-1:0];
        REG_SPT1:  spt_cfg[1] = val[SPT_W-1:0];
        REG_HDS1:  hds_cfg[1] = val[HDS_W-1:0];
        REG_CTL1:  ctl_cfg[1] = val[CTL_W-1:0];
        REG_LIMIT: chunk_limit = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // split the request into chunks and work out each command word
    function void note_request(chs_request_t r);
      logic [31:0] blk, trk, sec, head, cyl, spt, hds, lim, left, chunk;
      chs_word_t w;
      requests++;
      spt = (spt_cfg[r.drive] == 0) ? 32'd1 : 32'(spt_cfg[r.drive]);
      hds = (hds_cfg[r.drive] == 0) ? 32'd1 : 32'(hds_cfg[r.drive]);
      lim = (chunk_limit == 0) ? 32'd1 : 32'(chunk_limit);
      left = (r.sector_count > COUNT_LIMIT) ? 32'(COUNT_LIMIT) : 32'(r.sector_count);
      blk = 32'(r.start_block);
      while (left != 0) begin
        chunk = (left < lim) ? left : lim;
        trk = blk / spt;
        sec = blk % spt;
        head = trk % hds;
        cyl = trk / hds;
        left = left - chunk;
        w.opcode = r.action ? OPC_WRITE : OPC_READ;
        w.drive_head = {2'b00, r.drive, head[4:0]};
        w.cyl_high_sector = {cyl[9:8], sec[5:0]};
        w.cyl_low = cyl[7:0];
        w.chunk_count = chunk[7:0];
        w.control = ctl_cfg[r.drive];
        w.transfer = 16'(chunk * BYTES_PER_SECTOR);
        w.last = (left == 0);
        words_due.push_back(w);
        blk = blk + chunk;
      end
    endfunction

    function void compare(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_word(chs_word_t got);
      chs_word_t exp;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected command word, expected none, got %h", $time, got);
        errors++;
      end else begin
        exp = words_due.pop_front();
        words_seen++;
        compare("opcode", exp.opcode, got.opcode);
        compare("drive/head", exp.drive_head, got.drive_head);
        compare("cyl high/sector", exp.cyl_high_sector, got.cyl_high_sector);
        compare("cyl low", exp.cyl_low, got.cyl_low);
        compare("chunk count", exp.chunk_count, got.chunk_count);
        compare("control", exp.control, got.control);
        compare("transfer bytes", exp.transfer, got.transfer);
        compare("last", exp.last, got.last);
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = 1'b0;
  logic                 in_drive = 1'b0;
  logic [20:0]          in_start_block = '0;
  logic [CNT_W-1:0]     in_sector_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_opcode_byte;
  logic [7:0]           out_drive_head_byte;
  logic [7:0]           out_cyl_high_sector_byte;
  logic [7:0]           out_cyl_low_byte;
  logic [7:0]           out_chunk_count_byte;
  logic [7:0]           out_control_out_byte;
  logic [15:0]          out_transfer_bytes;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  chs_scoreboard sb;
  chs_word_t     got_word;
  bit            calm_phase = 1'b0;
  int            stall_hold = 0;
  int            stall_pick;
  int            cycle_count = 0;
  int            configs_run = 1;

  disk_request_to_chs_commands #(
    .READ_OPCODE (OPC_READ),
    .WRITE_OPCODE(OPC_WRITE),
    .SECTOR_BYTES(BYTES_PER_SECTOR)
  ) u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_action               (in_action),
    .in_drive                (in_drive),
    .in_start_block          (in_start_block),
    .in_sector_count         (in_sector_count),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_opcode_byte         (out_opcode_byte),
    .out_drive_head_byte     (out_drive_head_byte),
    .out_cyl_high_sector_byte(out_cyl_high_sector_byte),
    .out_cyl_low_byte        (out_cyl_low_byte),
    .out_chunk_count_byte    (out_chunk_count_byte),
    .out_control_out_byte    (out_control_out_byte),
    .out_transfer_bytes      (out_transfer_bytes),
    .out_last                (out_last),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver back-pressure: mostly short bursts, now and then a long hold, none in the calm phase
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm_phase) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 4);
      end else if (stall_pick < 92) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_word.opcode = out_opcode_byte;
      got_word.drive_head = out_drive_head_byte;
      got_word.cyl_high_sector = out_cyl_high_sector_byte;
      got_word.cyl_low = out_cyl_low_byte;
      got_word.chunk_count = out_chunk_count_byte;
      got_word.control = out_control_out_byte;
      got_word.transfer = out_transfer_bytes;
      got_word.last = out_last;
      sb.check_word(got_word);
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm_phase || p < 50) return 0;
    else if (p < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  function automatic chs_request_t make_req(logic act, logic drv, logic [20:0] blk,
                                            logic [CNT_W-1:0] cnt);
    chs_request_t r;
    r.action = act;
    r.drive = drv;
    r.start_block = blk;
    r.sector_count = cnt;
    return r;
  endfunction

  // small counts dominate so that one-sector chunking stays affordable
  function automatic chs_request_t rand_request();
    chs_request_t r;
    int p;
    r.action = $urandom_range(0, 1);
    r.drive = $urandom_range(0, 1);
    p = $urandom_range(0, 7);
    if (p == 0) r.start_block = TOP_BLOCK - 21'($urandom_range(0, 100));
    else if (p == 1) r.start_block = 21'($urandom_range(0, 200));
    else r.start_block = 21'($urandom);
    p = $urandom_range(0, 99);
    if (p < 8) r.sector_count = '0;
    else if (p < 70) r.sector_count = CNT_W'($urandom_range(1, 8));
    else if (p < 88) r.sector_count = CNT_W'($urandom_range(9, 64));
    else if (p < 94) r.sector_count = CNT_W'(COUNT_LIMIT);
    else r.sector_count = CNT_W'($urandom_range(65, 127));
    return r;
  endfunction

  function automatic geometry_set_t rand_geometry();
    geometry_set_t g;
    int p;
    for (int d = 0; d < 2; d++) begin
      p = $urandom_range(0, 9);
      g[d ? REG_SPT1 : REG_SPT0] = (p == 0) ? 8'd0 :
                                   (p == 1) ? 8'($urandom_range(0, 255)) :
                                   8'($urandom_range(1, 64));
      p = $urandom_range(0, 9);
      g[d ? REG_HDS1 : REG_HDS0] = (p == 0) ? 8'd0 :
                                   (p == 1) ? 8'($urandom_range(0, 255)) :
                                   8'($urandom_range(1, 32));
      g[d ? REG_CTL1 : REG_CTL0] = 8'($urandom_range(0, 255));
    end
    p = $urandom_range(0, 9);
    g[REG_LIMIT] = (p == 0) ? 8'd1 :
                   (p == 1) ? 8'($urandom_range(0, 255)) :
                   8'($urandom_range(1, 64));
    return g;
  endfunction

  task automatic send_item(input chs_request_t r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    in_drive <= r.drive;
    in_start_block <= r.start_block;
    in_sector_count <= r.sector_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_item(rand_request(), pick_gap());
  endtask

  // drain everything, then idle so that a stray word from a zero-sector request would be caught
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || in_stall) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic load_config(input geometry_set_t g, input logic [CFG_DAT_W-1:0] spare);
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 7; i++) begin
      idx = CFG_IDX_W'(i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= g[i];
      @(posedge clk);
      sb.set_reg(idx, g[i]);
    end
    // writes past the last register must leave everything alone
    cfg_index <= REG_UNUSED;
    cfg_wdata <= spare;
    @(posedge clk);
    sb.set_reg(REG_UNUSED, spare);
    cfg_we <= 1'b0;
    configs_run++;
  endtask

  initial begin
    geometry_set_t g;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, one sector per word
    send_item(make_req(ACT_READ, 1'b0, 21'd0, 7'd1), 0);
    send_item(make_req(ACT_WRITE, 1'b1, TOP_BLOCK, 7'd3), 0);
    send_item(make_req(ACT_READ, 1'b0, 21'd0, 7'd0), pick_gap());
    send_item(make_req(ACT_WRITE, 1'b0, 21'd1000, 7'd2), pick_gap());
    send_item(make_req(ACT_READ, 1'b1, 21'd102005, 7'd1), pick_gap());
    settle();

    // largest geometry on drive zero, smallest on drive one, full chunks
    g[REG_SPT0] = 8'd64;
    g[REG_HDS0] = 8'd32;
    g[REG_CTL0] = 8'hFF;
    g[REG_SPT1] = 8'd1;
    g[REG_HDS1] = 8'd1;
    g[REG_CTL1] = 8'h5A;
    g[REG_LIMIT] = 8'd64;
    load_config(g, 8'hC3);
    send_item(make_req(ACT_READ, 1'b0, TOP_BLOCK, 7'd64), 0);
    send_item(make_req(ACT_WRITE, 1'b0, 21'd0, 7'd127), 0);
    send_item(make_req(ACT_READ, 1'b1, 21'd777, 7'd65), pick_gap());
    send_item(make_req(ACT_WRITE, 1'b1, 21'd12345, 7'd64), pick_gap());
    send_item(make_req(ACT_READ, 1'b0, 21'd4095, 7'd0), pick_gap());
    send_random(40);
    settle();

    // zero geometry and zero limit, oversized values masked down
    g[REG_SPT0] = 8'd0;
    g[REG_HDS0] = 8'd0;
    g[REG_CTL0] = 8'h00;
    g[REG_SPT1] = 8'hFF;
    g[REG_HDS1] = 8'hFF;
    g[REG_CTL1] = 8'hA5;
    g[REG_LIMIT] = 8'd0;
    load_config(g, 8'h3C);
    send_item(make_req(ACT_WRITE, 1'b0, 21'd5, 7'd3), 0);
    send_item(make_req(ACT_READ, 1'b1, TOP_BLOCK, 7'd4), 0);
    send_item(make_req(ACT_WRITE, 1'b1, 21'd1000, 7'd2), pick_gap());
    send_random(40);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      calm_phase = (ph == 2);
      load_config(rand_geometry(), 8'($urandom_range(0, 255)));
      send_random(46);
      settle();
    end

    $display("sent %0d requests through %0d register settings", sb.requests, configs_run);
    $display("checked %0d command words, %0d mismatches", sb.words_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
